FILE: rtl/tdc_pkg.sv
// Shared types and constants for the 12-hour time-of-day clock.
// No dependencies; used by every module of the block.
`default_nettype none

package tdc_pkg;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_SET    = 2'd1,
		REQ_ADJUST = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef logic [10:0] minute_t;

	localparam logic [15:0] TPM_RESET      = 16'd60000;
	localparam logic [11:0] MIN_PER_DAY    = 12'd1440;
	localparam logic [10:0] LAST_MINUTE    = 11'd1439;
	// 2^31 mod 1440 is 128; bias undoes the sign-bit flip
	localparam logic [11:0] WRAP_BIAS      = 12'd1312;
	localparam logic [14:0] RECIP45        = 15'd23302;  // ceil(2^20 / 45)
	localparam logic [13:0] MOD45          = 14'd45;
	localparam logic [10:0] RECIP60        = 11'd1093;   // ceil(2^16 / 60)
	localparam logic [10:0] MIN_PER_HOUR   = 11'd60;
	localparam logic [4:0]  HOURS_PER_HALF = 5'd12;

endpackage

`default_nettype wire

FILE: rtl/tdc_wrap.sv
// Input register and two-stage wrap of a signed minute value into 0..1439.
// Depends on tdc_pkg.
`default_nettype none

module tdc_wrap (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tdc_pkg::req_t     in_req,
	input  wire logic [31:0]       in_set,
	input  wire logic [15:0]       in_delta,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tdc_pkg::req_t          out_req,
	output tdc_pkg::minute_t       out_wrap
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	tdc_pkg::req_t req_s1, req_s2, req_s3;
	logic [31:0]   set_s1;
	logic [15:0]   delta_s1;
	logic [13:0]   csum_s2;
	logic [7:0]    q_s2;
	logic [4:0]    lo_s2;
	tdc_pkg::minute_t w_s3;

	logic [31:0] x, xu;
	logic [26:0] y;
	logic [13:0] csum;
	logic [28:0] prod;

	logic [13:0] rem;
	logic [10:0] m0;
	logic [11:0] m1, m2;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// fold: x mod 1440 = ((xu>>5) mod 45)*32 + xu[4:0] + bias, and 2^12 = 1 mod 45
	always_comb begin
		x    = (req_s1 == tdc_pkg::REQ_SET) ? set_s1 : {{16{delta_s1[15]}}, delta_s1};
		xu   = x ^ 32'h8000_0000;
		y    = xu[31:5];
		csum = 14'(y[11:0]) + 14'(y[23:12]) + 14'(y[26:24]);
		prod = 29'(csum) * 29'(tdc_pkg::RECIP45);
	end

	always_comb begin
		rem = csum_s2 - 14'(q_s2) * tdc_pkg::MOD45;
		m0  = {rem[5:0], lo_s2};
		m1  = 12'(m0) + tdc_pkg::WRAP_BIAS;
		m2  = (m1 >= tdc_pkg::MIN_PER_DAY) ? m1 - tdc_pkg::MIN_PER_DAY : m1;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1   <= in_req;
			set_s1   <= in_set;
			delta_s1 <= in_delta;
		end
		if (en_s2) begin
			req_s2  <= req_s1;
			csum_s2 <= csum;
			q_s2    <= prod[27:20];
			lo_s2   <= xu[4:0];
		end
		if (en_s3) begin
			req_s3 <= req_s2;
			w_s3   <= m2[10:0];
		end
	end

	assign out_valid = v_s3;
	assign out_req   = req_s3;
	assign out_wrap  = w_s3;

	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (12'(w_s3) < tdc_pkg::MIN_PER_DAY))
		else $error("wrapped minute out of range");

endmodule

`default_nettype wire

FILE: rtl/tdc_state.sv
// Clock state (valid flag, minute and tick counters), rate register, state update.
// Depends on tdc_pkg.
`default_nettype none

module tdc_state (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [15:0]       cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tdc_pkg::req_t     in_req,
	input  wire tdc_pkg::minute_t  in_wrap,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_flag,
	output tdc_pkg::minute_t       out_minute
);

	logic [15:0]      tpm_val_q;
	logic             flag_q;
	tdc_pkg::minute_t min_q;
	logic [15:0]      tick_q;

	logic             flag_n;
	tdc_pkg::minute_t min_n;
	logic [15:0]      tick_n;

	logic [16:0]      tick_inc;
	logic             roll;
	tdc_pkg::minute_t min_inc;
	logic [11:0]      adj_sum, adj_wrap;
	logic             take;

	logic             v_s4;
	logic             flag_s4;
	tdc_pkg::minute_t min_s4;

	assign in_ready = !v_s4 || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		tick_inc = 17'(tick_q) + 17'd1;
		roll     = tick_inc >= 17'(tpm_val_q);
		min_inc  = (min_q == tdc_pkg::LAST_MINUTE) ? 11'd0 : min_q + 11'd1;
		adj_sum  = 12'(flag_q ? min_q : 11'd0) + 12'(in_wrap);
		adj_wrap = (adj_sum >= tdc_pkg::MIN_PER_DAY) ? adj_sum - tdc_pkg::MIN_PER_DAY : adj_sum;
	end

	always_comb begin
		flag_n = flag_q;
		min_n  = min_q;
		tick_n = tick_q;
		case (in_req)
			tdc_pkg::REQ_TICK: begin
				if (flag_q) begin
					if (roll) begin
						tick_n = 16'd0;
						min_n  = min_inc;
					end else begin
						tick_n = tick_inc[15:0];
					end
				end
			end
			tdc_pkg::REQ_SET: begin
				flag_n = 1'b1;
				min_n  = in_wrap;
				tick_n = 16'd0;
			end
			tdc_pkg::REQ_ADJUST: begin
				flag_n = 1'b1;
				min_n  = adj_wrap[10:0];
				tick_n = 16'd0;
			end
			tdc_pkg::REQ_READ: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_val_q <= tdc_pkg::TPM_RESET;
			flag_q    <= 1'b0;
			min_q     <= '0;
			tick_q    <= '0;
			v_s4      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tpm_val_q <= cfg_wr_data;
			end
			if (take) begin
				flag_q <= flag_n;
				min_q  <= min_n;
				tick_q <= tick_n;
			end
			if (in_ready) v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			flag_s4 <= flag_n;
			min_s4  <= min_n;
		end
	end

	assign out_valid  = v_s4;
	assign out_flag   = flag_s4;
	assign out_minute = min_s4;

	a_unset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!flag_q |-> (min_q == 11'd0 && tick_q == 16'd0))
		else $error("unset clock holds nonzero counters");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		12'(min_q) < tdc_pkg::MIN_PER_DAY)
		else $error("minute count out of range");

	a_cfg_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (tpm_val_q == $past(cfg_wr_data)))
		else $error("rate register write lost");

endmodule

`default_nettype wire

FILE: rtl/tdc_fmt.sv
// Two-stage split of minutes of day into 12-hour hour, minute and AM/PM,
// with the output register. Depends on tdc_pkg.
`default_nettype none

module tdc_fmt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_flag,
	input  wire tdc_pkg::minute_t  in_minute,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   clock_valid,
	output tdc_pkg::minute_t       minutes_of_day,
	output logic [3:0]             hour_12,
	output logic [5:0]             minute_of_hour,
	output logic                   is_pm
);

	logic v_s5, v_s6;
	logic en_s5, en_s6;

	logic [21:0]      prod;
	logic             flag_s5;
	tdc_pkg::minute_t min_s5;
	logic [4:0]       h24_s5;

	logic [10:0]      mh;
	logic             pm;
	logic [4:0]       h, h12;

	logic             flag_s6;
	tdc_pkg::minute_t min_s6;
	logic [3:0]       h12_s6;
	logic [5:0]       moh_s6;
	logic             pm_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	assign prod = 22'(in_minute) * 22'(tdc_pkg::RECIP60);

	always_comb begin
		mh  = min_s5 - 11'(h24_s5) * tdc_pkg::MIN_PER_HOUR;
		pm  = h24_s5 >= tdc_pkg::HOURS_PER_HALF;
		h   = pm ? h24_s5 - tdc_pkg::HOURS_PER_HALF : h24_s5;
		h12 = (h == 5'd0) ? tdc_pkg::HOURS_PER_HALF : h;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			flag_s5 <= in_flag;
			min_s5  <= in_minute;
			h24_s5  <= prod[20:16];
		end
		if (en_s6) begin
			flag_s6 <= flag_s5;
			min_s6  <= flag_s5 ? min_s5 : 11'd0;
			h12_s6  <= flag_s5 ? h12[3:0] : 4'd0;
			moh_s6  <= flag_s5 ? mh[5:0] : 6'd0;
			pm_s6   <= flag_s5 && pm;
		end
	end

	assign out_valid      = v_s6;
	assign clock_valid    = flag_s6;
	assign minutes_of_day = min_s6;
	assign hour_12        = h12_s6;
	assign minute_of_hour = moh_s6;
	assign is_pm          = pm_s6;

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && flag_s6) |-> (h12_s6 != 4'd0 && h12_s6 <= 4'd12 && moh_s6 < 6'd60))
		else $error("12-hour fields out of range");

endmodule

`default_nettype wire

FILE: rtl/time_of_day_clock_12h_core.sv
// Time-of-day clock with 12-hour view: top level, stream ports and stage wiring.
// Depends on tdc_pkg, tdc_wrap, tdc_state, tdc_fmt.
// Six register stages, s1 to s6; a word accepted into s1 is offered as its result word from s6.
// Throughput: one word per cycle; each stage holds its word under back-pressure.
// Reset (async, active low): clock unset, counters zero, ticks per minute 60000.
`default_nettype none

module time_of_day_clock_12h_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // set_minutes[31:0], delta_minutes[47:32]
	input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // minutes_of_day[10:0], hour_12[14:11],
	                                         // minute_of_hour[20:15], is_pm[21], zero[23:22]
	output logic             m_axis_tuser    // clock_valid
);

	logic             w_valid, w_ready;
	tdc_pkg::req_t    w_req;
	tdc_pkg::minute_t w_wrap;

	logic             st_valid, st_ready, st_flag;
	tdc_pkg::minute_t st_minute;

	tdc_pkg::minute_t mod_w;
	logic [3:0]       h12_w;
	logic [5:0]       moh_w;
	logic             pm_w;

	tdc_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (tdc_pkg::req_t'(s_axis_tuser)),
		.in_set    (s_axis_tdata[31:0]),
		.in_delta  (s_axis_tdata[47:32]),
		.out_valid (w_valid),
		.out_ready (w_ready),
		.out_req   (w_req),
		.out_wrap  (w_wrap)
	);

	tdc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (w_valid),
		.in_ready    (w_ready),
		.in_req      (w_req),
		.in_wrap     (w_wrap),
		.out_valid   (st_valid),
		.out_ready   (st_ready),
		.out_flag    (st_flag),
		.out_minute  (st_minute)
	);

	tdc_fmt u_fmt (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (st_valid),
		.in_ready       (st_ready),
		.in_flag        (st_flag),
		.in_minute      (st_minute),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.clock_valid    (m_axis_tuser),
		.minutes_of_day (mod_w),
		.hour_12        (h12_w),
		.minute_of_hour (moh_w),
		.is_pm          (pm_w)
	);

	assign m_axis_tdata = {2'b00, pm_w, moh_w, h12_w, mod_w};

endmodule

`default_nettype wire
